[rtl/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and constants of the polar scan to points converter.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

  // Field widths of the stream items.
  localparam int BEAM_W      = 10;
  localparam int RANGE_W     = 16;
  localparam int COORD_W     = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    REG_ANGLE_STEP  = 1'b0,
    REG_RANGE_LIMIT = 1'b1
  } psp_reg_t;

  // Binary angle: 2^24 units per turn, widened by 8 bits for the rotator.
  localparam int ANG_W     = 24;
  localparam int ANG_SHIFT = 8;

  // Rotator datapath.
  localparam int XY_W            = 33;
  localparam int Z_W             = 32;
  localparam int CORDIC_STEPS    = 30;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / ITERS_PER_STAGE;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

  // Product of range and a Q2.30 value, and the rounded magnitude.
  localparam int PROD_W = XY_W + RANGE_W + 1;
  localparam int FRAC_W = 30;
  localparam int MAG_W  = PROD_W - FRAC_W;

  localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Side information that travels down the pipeline with each item.
  typedef struct packed {
    logic               vld;
    logic               kept;
    logic [1:0]         quad;
    logic [RANGE_W-1:0] rng;
  } psp_side_t;

  // Rotator state.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic        [Z_W-1:0]  z;
  } psp_rot_t;

  // One finished result.
  typedef struct packed {
    logic               kept;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } psp_pt_t;

  // One rotation step; shifts are arithmetic (toward minus infinity).
  function automatic psp_rot_t rot_step(input psp_rot_t a, input int unsigned i);
    psp_rot_t               r;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    dx = $signed(a.y) >>> i;
    dy = $signed(a.x) >>> i;
    if (!a.z[Z_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ATAN_TAB[i];
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ATAN_TAB[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/polar_scan_to_points_top.sv]
// ----------------------------------------------------------------------------
// polar_scan_to_points_top
// Laser range sample to Cartesian point converter with APB configuration.
// ----------------------------------------------------------------------------
// Each input item carries a beam index and a range sample and produces exactly
// one output item, in order. The beam angle is the index (reduced modulo
// MAX_BEAMS) times angle_step, wrapped to 24 bits where 2^24 is one turn.
// A sample whose range is above range_limit comes out with kept low and a zero
// point; otherwise x = range*cos and y = range*sin, rounded half away from zero
// and saturated to +/-(2^RANGE_BITS - 1). The block accepts one item per
// clock while the output buffer has a free entry. An item passes through 21
// registers: three stages for range check, index reduction and angle
// multiply, fifteen rotator stages of two rotation steps each, two stages for
// quadrant mapping and the range multiply, and the output register that also
// rounds. The first stage captures the item at the edge that accepts it. A
// two-entry output buffer sits after the pipeline; the whole pipeline holds
// only while both entries are occupied, so s_tready does not depend on
// m_tready in the same cycle. Configuration is written through the APB port
// at byte address 0 (angle_step) and 4 (range_limit); the user must write it
// only while no item is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_scan_to_points_top #(
  parameter int MAX_BEAMS  = 1024,
  parameter int RANGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [psp_pkg::IN_TDATA_W-1:0]  s_tdata,   // beam_index[9:0], range_sample[25:10]
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psp_pkg::OUT_TDATA_W-1:0] m_tdata,   // point_x[16:0], point_y[33:17]
  output logic                            m_tuser,   // kept[0]
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psp_pkg::APB_AW-1:0]      paddr,
  input  logic [psp_pkg::APB_DW-1:0]      pwdata,
  output logic [psp_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import psp_pkg::*;

  // Configuration registers.
  logic [ANG_W-1:0]   angle_step;
  logic [RANGE_W-1:0] range_limit;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step  <= '0;
      range_limit <= '1;
    end else if (cfg_wr) begin
      case (psp_reg_t'(paddr[2]))
        REG_ANGLE_STEP:  angle_step  <= pwdata[ANG_W-1:0];
        REG_RANGE_LIMIT: range_limit <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (psp_reg_t'(paddr[2]))
      REG_ANGLE_STEP:  prdata = APB_DW'(angle_step);
      REG_RANGE_LIMIT: prdata = APB_DW'(range_limit);
      default:         prdata = '0;
    endcase
  end

  // The pipeline advances whenever the output buffer has a free entry.
  logic [1:0] fill, fill_next;
  logic       en, push, pop;

  psp_side_t        ang_side, cor_side, sc_side;
  logic [ANG_W-1:0] ang;
  psp_rot_t         cor_rot;
  psp_pt_t          sc_pt;
  psp_pt_t          head, skid;

  assign en       = (fill != 2'd2);
  assign s_tready = en;

  psp_angle #(
    .MAX_BEAMS  (MAX_BEAMS),
    .RANGE_BITS (RANGE_BITS)
  ) u_angle (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (s_tvalid),
    .beam_index   (s_tdata[BEAM_W-1:0]),
    .range_sample (s_tdata[BEAM_W+RANGE_W-1:BEAM_W]),
    .angle_step   (angle_step),
    .range_limit  (range_limit),
    .side_out     (ang_side),
    .angle_out    (ang)
  );

  psp_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (ang_side),
    .angle_in (ang),
    .side_out (cor_side),
    .rot_out  (cor_rot)
  );

  psp_scale #(
    .RANGE_BITS (RANGE_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (cor_side),
    .rot_in   (cor_rot),
    .side_out (sc_side),
    .pt_out   (sc_pt)
  );

  // Two-entry output buffer: head drives the port, skid catches the item that
  // leaves the pipeline in the cycle the buffer becomes full.
  assign push     = en && sc_side.vld;
  assign m_tvalid = (fill != 2'd0);
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    case ({push, pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (fill == 2'd0 || (fill == 2'd1 && pop))) begin
      head <= sc_pt;
    end else if (pop && fill == 2'd2) begin
      head <= skid;
    end
    if (push && fill == 2'd1 && !pop) begin
      skid <= sc_pt;
    end
  end

  assign m_tuser = head.kept;
  assign m_tdata = OUT_TDATA_W'({head.y, head.x});

  // The buffer never holds more than two items.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("output buffer overfilled");

  // A sample that is not kept must come out with a zero point.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("skipped sample with nonzero point");

  // While the pipeline holds, the last stage keeps its item.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sc_side.vld))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

[rtl/psp_angle.sv]
// ----------------------------------------------------------------------------
// psp_angle
// Range check, beam index reduction and beam angle multiply (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module psp_angle #(
  parameter int MAX_BEAMS  = 1024,
  parameter int RANGE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [psp_pkg::BEAM_W-1:0]  beam_index,
  input  logic [psp_pkg::RANGE_W-1:0] range_sample,
  input  logic [psp_pkg::ANG_W-1:0]   angle_step,
  input  logic [psp_pkg::RANGE_W-1:0] range_limit,
  output psp_pkg::psp_side_t          side_out,
  output logic [psp_pkg::ANG_W-1:0]   angle_out
);
  import psp_pkg::*;

  localparam logic [RANGE_W-1:0] RANGE_MASK =
    RANGE_W'((64'd1 << RANGE_BITS) - 64'd1);
  localparam int SPLIT = BEAM_W / 2;

  // Restoring reduction of the index by MAX_BEAMS, shifted copies hi down to lo.
  function automatic logic [BEAM_W-1:0] reduce(input logic [BEAM_W-1:0] v,
                                               input int hi, input int lo);
    logic [BEAM_W-1:0] r;
    r = v;
    for (int k = hi; k >= lo; k--) begin
      if ((longint'(MAX_BEAMS) << k) < (longint'(1) << BEAM_W)) begin
        if (longint'(r) >= (longint'(MAX_BEAMS) << k)) begin
          r = r - BEAM_W'(longint'(MAX_BEAMS) << k);
        end
      end
    end
    return r;
  endfunction

  psp_side_t          side1, side2;
  logic [BEAM_W-1:0]  beam1, beam2;
  logic [RANGE_W-1:0] rng_in;
  logic [BEAM_W+ANG_W-1:0] prod;

  assign rng_in = range_sample & RANGE_MASK;
  assign prod   = {{ANG_W{1'b0}}, beam2} * {{BEAM_W{1'b0}}, angle_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      side1.vld    <= 1'b0;
      side2.vld    <= 1'b0;
      side_out.vld <= 1'b0;
    end else if (en) begin
      side1.vld  <= in_vld;
      side1.kept <= (rng_in <= range_limit);
      side1.quad <= 2'b00;
      side1.rng  <= rng_in;
      side2      <= side1;
      side_out   <= side2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beam1     <= reduce(beam_index, BEAM_W - 1, SPLIT);
      beam2     <= reduce(beam1, SPLIT - 1, 0);
      angle_out <= prod[ANG_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/psp_cordic.sv]
// ----------------------------------------------------------------------------
// psp_cordic
// Pipelined rotator producing cosine and sine of the residual angle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_cordic (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  psp_pkg::psp_side_t        side_in,
  input  logic [psp_pkg::ANG_W-1:0] angle_in,
  output psp_pkg::psp_side_t        side_out,
  output psp_pkg::psp_rot_t         rot_out
);
  import psp_pkg::*;

  psp_rot_t  rot  [CORDIC_STAGES];
  psp_side_t side [CORDIC_STAGES];
  psp_rot_t  rot_first;
  psp_side_t side_first;

  // The rotation steps that one stage performs.
  function automatic psp_rot_t stage_step(input psp_rot_t a, input int g);
    psp_rot_t r;
    r = a;
    for (int k = 0; k < ITERS_PER_STAGE; k++) begin
      r = rot_step(r, g * ITERS_PER_STAGE + k);
    end
    return r;
  endfunction

  // The top two angle bits pick the quadrant; the rest is the residual angle.
  always_comb begin
    rot_first.x     = GAIN_Q30;
    rot_first.y     = '0;
    rot_first.z     = Z_W'({angle_in[ANG_W-3:0], {ANG_SHIFT{1'b0}}});
    side_first      = side_in;
    side_first.quad = angle_in[ANG_W-1:ANG_W-2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < CORDIC_STAGES; g++) begin
        side[g].vld <= 1'b0;
      end
    end else if (en) begin
      side[0] <= side_first;
      for (int g = 1; g < CORDIC_STAGES; g++) begin
        side[g] <= side[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot[0] <= stage_step(rot_first, 0);
      for (int g = 1; g < CORDIC_STAGES; g++) begin
        rot[g] <= stage_step(rot[g-1], g);
      end
    end
  end

  assign side_out = side[CORDIC_STAGES-1];
  assign rot_out  = rot[CORDIC_STAGES-1];

endmodule

`default_nettype wire

[rtl/psp_scale.sv]
// ----------------------------------------------------------------------------
// psp_scale
// Quadrant mapping, range multiply, then rounding and saturation of x and y.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_scale #(
  parameter int RANGE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  psp_pkg::psp_side_t side_in,
  input  psp_pkg::psp_rot_t  rot_in,
  output psp_pkg::psp_side_t side_out,
  output psp_pkg::psp_pt_t   pt_out
);
  import psp_pkg::*;

  localparam logic [MAG_W:0] LIM =
    (RANGE_BITS >= MAG_W) ? {(MAG_W + 1){1'b1}}
                          : (MAG_W + 1)'((64'd1 << RANGE_BITS) - 64'd1);

  // Round half away from zero, saturate, keep the low coordinate bits.
  function automatic logic [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [MAG_W-1:0]  r;
    logic [MAG_W-1:0]  sv;
    neg = p[PROD_W-1];
    mag = neg ? (PROD_W'(0) - PROD_W'(p)) : PROD_W'(p);
    sum = mag + (PROD_W'(1) << (FRAC_W - 1));
    r   = sum[PROD_W-1:FRAC_W];
    if ({1'b0, r} > LIM) begin
      r = LIM[MAG_W-1:0];
    end
    sv = neg ? (MAG_W'(0) - r) : r;
    return sv[COORD_W-1:0];
  endfunction

  psp_side_t              side_q;
  logic signed [XY_W-1:0] c_q, s_q;
  logic signed [XY_W-1:0] c_nx, s_nx;
  logic signed [PROD_W-1:0] px, py;

  always_comb begin
    case (side_in.quad)
      2'd0: begin
        c_nx = rot_in.x;
        s_nx = rot_in.y;
      end
      2'd1: begin
        c_nx = -rot_in.y;
        s_nx = rot_in.x;
      end
      2'd2: begin
        c_nx = -rot_in.x;
        s_nx = -rot_in.y;
      end
      default: begin
        c_nx = rot_in.y;
        s_nx = -rot_in.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_q.vld   <= 1'b0;
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_q   <= side_in;
      side_out <= side_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q <= c_nx;
      s_q <= s_nx;
      px  <= PROD_W'($signed({1'b0, side_q.rng})) * PROD_W'(c_q);
      py  <= PROD_W'($signed({1'b0, side_q.rng})) * PROD_W'(s_q);
    end
  end

  // A sample that is not kept reports a zero point.
  always_comb begin
    pt_out.kept = side_out.kept;
    pt_out.x    = side_out.kept ? round_sat(px) : '0;
    pt_out.y    = side_out.kept ? round_sat(py) : '0;
  end

endmodule

`default_nettype wire

[sim/psp_point_check_pkg.sv]
// ----------------------------------------------------------------------------
// psp_point_check_pkg
// Expected-point tracker for the polar scan to points converter bench.
// ----------------------------------------------------------------------------
// Holds a shadow copy of the two configuration registers. For every sample
// that the converter accepts, it computes the expected point with its own
// fixed-point rotator. It queues that point and compares each point that
// leaves the converter against the oldest one in the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_point_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;

  // Coordinates saturate at the largest range value.
  localparam longint SAT_LIMIT = 65535;
  localparam longint GAIN_Q30_VAL = 652032874;
  localparam int ROT_STEPS = 30;

  typedef struct packed {
    bit               kept;
    bit [COORD_W-1:0] x;
    bit [COORD_W-1:0] y;
  } scan_point_t;

  class scan_point_tracker;
    bit [ANG_W-1:0]   angle_step;
    bit [RANGE_W-1:0] range_limit;
    scan_point_t      expected_points[$];
    int               errors;

    function new();
      angle_step  = '0;
      range_limit = 16'hFFFF;
      errors      = 0;
    endfunction

    function void set_reg(psp_reg_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_ANGLE_STEP:  angle_step  = value[ANG_W-1:0];
        REG_RANGE_LIMIT: range_limit = value[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Arctangent of 2^-i, in units where 2^32 is one turn.
    function longint arctan(int i);
      case (i)
        0:  return 64'h20000000;
        1:  return 64'h12E4051E;
        2:  return 64'h09FB385B;
        3:  return 64'h051111D4;
        4:  return 64'h028B0D43;
        5:  return 64'h0145D7E1;
        6:  return 64'h00A2F61E;
        7:  return 64'h00517C55;
        8:  return 64'h0028BE53;
        9:  return 64'h00145F2F;
        10: return 64'h000A2F98;
        11: return 64'h000517CC;
        12: return 64'h00028BE6;
        13: return 64'h000145F3;
        14: return 64'h0000A2FA;
        15: return 64'h0000517D;
        16: return 64'h000028BE;
        17: return 64'h0000145F;
        18: return 64'h00000A30;
        19: return 64'h00000518;
        20: return 64'h0000028C;
        21: return 64'h00000146;
        22: return 64'h000000A3;
        23: return 64'h00000051;
        24: return 64'h00000029;
        25: return 64'h00000014;
        26: return 64'h0000000A;
        27: return 64'h00000005;
        28: return 64'h00000003;
        default: return 64'h00000001;
      endcase
    endfunction

    // The range is multiplied by a Q2.30 value and rounded half away from zero.
    function longint round_to_units(longint rng, longint q30);
      longint p;
      longint mag;
      longint r;
      p   = rng * q30;
      mag = (p < 0) ? -p : p;
      r   = (mag + (longint'(1) << 29)) >>> 30;
      if (r > SAT_LIMIT) r = SAT_LIMIT;
      return (p < 0) ? -r : r;
    endfunction

    function void note_sample(bit [BEAM_W-1:0] beam, bit [RANGE_W-1:0] rng);
      scan_point_t e;
      bit [33:0]   prod;
      bit [31:0]   ang;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      longint      c;
      longint      s;
      longint      px;
      longint      py;
      e = '0;
      if (rng <= range_limit) begin
        prod = 34'(beam) * 34'(angle_step);
        ang  = {prod[ANG_W-1:0], 8'h00};
        z    = longint'(ang[29:0]);
        x    = GAIN_Q30_VAL;
        y    = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan(i);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan(i);
          end
        end
        // The two top angle bits pick the quadrant.
        case (ang[31:30])
          2'd0: begin c = x;  s = y;  end
          2'd1: begin c = -y; s = x;  end
          2'd2: begin c = -x; s = -y; end
          default: begin c = y; s = -x; end
        endcase
        px     = round_to_units(longint'(rng), c);
        py     = round_to_units(longint'(rng), s);
        e.kept = 1'b1;
        e.x    = px[COORD_W-1:0];
        e.y    = py[COORD_W-1:0];
      end
      expected_points.insert(expected_points.size(), e);
    endfunction

    function void check_point(bit kept, bit [COORD_W-1:0] px, bit [COORD_W-1:0] py);
      scan_point_t e;
      if (expected_points.size() == 0) begin
        $display("%0t: point with nothing expected: kept %0b x %0d y %0d",
                 $time, kept, $signed(px), $signed(py));
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (e.kept != kept) begin
        $display("%0t: kept expected %0b, got %0b", $time, e.kept, kept);
        errors++;
      end
      if (e.x != px) begin
        $display("%0t: point_x expected %0d, got %0d", $time, $signed(e.x), $signed(px));
        errors++;
      end
      if (e.y != py) begin
        $display("%0t: point_y expected %0d, got %0d", $time, $signed(e.y), $signed(py));
        errors++;
      end
    endfunction
  endclass

endpackage

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the polar scan to points converter.
// ----------------------------------------------------------------------------
// Writes both registers over the APB port between phases and streams range
// samples in bursts while the output side stalls on its own pattern. Every
// point that comes out is checked against the tracker's prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;
  import psp_point_check_pkg::*;

  // Output-side stall patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE,
    RX_PERIODIC
  } rx_mode_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // beam_index[9:0], range_sample[25:10]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // point_x[16:0], point_y[33:17]
  logic                   m_tuser;         // kept[0]
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  scan_point_tracker tracker;

  // Sender burst bookkeeping and the request count for long output holds.
  int burst_left = 0;
  int hold_reqs  = 0;

  // Receiver state, private to the receiver process.
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_left   = 0;
  int       rx_tick   = 0;
  rx_mode_t rx_mode   = RX_ALWAYS;

  polar_scan_to_points_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // A register write has a setup phase and an access phase. The shadow copy
  // in the tracker is updated once the access has completed, which is safe
  // because writes only happen while no item is in flight.
  task automatic write_reg(input psp_reg_t idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // Offers one sample and returns at the edge where it is accepted. The sender
  // works in bursts; between bursts it drops tvalid for a random gap, which is
  // occasionally long.
  task automatic send_sample(input logic [BEAM_W-1:0] beam, input logic [RANGE_W-1:0] rng);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, rng, beam};
    do @(posedge clk); while (!s_tready);
    tracker.note_sample(beam, rng);
    burst_left--;
  endtask

  // Stops offering items and waits until every expected point has come back.
  // Every sample produces a point, so nothing is left in flight afterwards.
  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (tracker.expected_points.size() != 0) @(posedge clk);
  endtask

  // Ranges lean toward the interesting spots: zero, full scale, the values
  // right around the limit, and small values, with plenty of uniform ones.
  function automatic logic [RANGE_W-1:0] pick_range(input logic [RANGE_W-1:0] limit);
    int r;
    case ($urandom_range(0, 9))
      0: r = 0;
      1: r = 65535;
      2, 3: begin
        r = int'(limit) + $urandom_range(0, 2) - 1;
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
      end
      4: r = $urandom_range(0, 255);
      default: r = $urandom_range(0, 65535);
    endcase
    return r[RANGE_W-1:0];
  endfunction

  // One configuration phase of scan-like traffic: beam indices mostly climb
  // by one and wrap, as they do in a real sweep, with a random jump now and
  // then. When asked, the receiver is told to hold off early in the phase
  // while the sender keeps going, so the pipeline fills and backs up.
  task automatic run_scan_phase(input logic [APB_DW-1:0] step_word,
                                input logic [APB_DW-1:0] limit_word,
                                input int count, input bit long_hold);
    logic [BEAM_W-1:0] beam;
    wait_drained();
    write_reg(REG_ANGLE_STEP, step_word);
    write_reg(REG_RANGE_LIMIT, limit_word);
    beam = BEAM_W'($urandom_range(0, 1023));
    for (int n = 0; n < count; n++) begin
      if (long_hold && n == 20) hold_reqs++;
      if ($urandom_range(0, 15) == 0) beam = BEAM_W'($urandom_range(0, 1023));
      else beam = beam + 1'b1;
      send_sample(beam, pick_range(tracker.range_limit));
    end
  endtask

  // Receiver: checks each accepted point and drives tready. A long hold takes
  // priority; otherwise it switches between stall patterns every so often,
  // including stretches where it never stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        tracker.check_point(m_tuser, m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W]);
      end
      rx_tick++;
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 300;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 200);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_ALWAYS:   m_tready <= 1'b1;
          RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
          RX_RARE:     m_tready <= ($urandom_range(0, 7) != 0);
          RX_PERIODIC: m_tready <= ((rx_tick % 5) != 0);
          default:     m_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With a step of 2^24/1024 the beams sweep one full turn,
    // so multiples of 128 land on the axes and diagonals, and full-scale
    // range at zero angle exercises saturation of the coordinates.
    write_reg(REG_ANGLE_STEP, 32'd16384);
    write_reg(REG_RANGE_LIMIT, 32'd65535);
    for (int k = 0; k < 8; k++) send_sample(10'(k * 128), 16'hFFFF);
    send_sample(10'd1023, 16'hFFFF);
    send_sample(10'd0, 16'd0);
    send_sample(10'd1, 16'd1);
    send_sample(10'd128, 16'd40000);

    // Largest step, so the beam-times-step product wraps past a full turn.
    // Both words carry junk above the register width, which must be ignored.
    // Ranges sit on, just over and far over a limit of 1000.
    wait_drained();
    write_reg(REG_ANGLE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RANGE_LIMIT, 32'hABCD_03E8);
    send_sample(10'd1023, 16'd1000);
    send_sample(10'd1023, 16'd1001);
    send_sample(10'd2, 16'hFFFF);
    send_sample(10'd3, 16'd0);
    send_sample(10'd700, 16'd999);

    // Exact quarter turns per beam with a zero limit: only range zero is kept.
    wait_drained();
    write_reg(REG_ANGLE_STEP, 32'h0040_0000);
    write_reg(REG_RANGE_LIMIT, 32'd0);
    send_sample(10'd1, 16'd0);
    send_sample(10'd2, 16'd1);
    send_sample(10'd3, 16'd0);

    // Random part, one configuration per phase, extremes included.
    run_scan_phase(32'd16384, 32'd65535, 228, 1'b0);
    run_scan_phase(32'd0, 32'd0, 228, 1'b0);
    run_scan_phase(32'h00FF_FFFF, $urandom_range(0, 65535), 228, 1'b0);
    run_scan_phase($urandom(), $urandom(), 228, 1'b0);
    run_scan_phase(32'd1, 32'd65535, 228, 1'b1);
    run_scan_phase($urandom_range(0, 65535), 32'd32768, 228, 1'b0);
    run_scan_phase($urandom(), $urandom_range(0, 65535), 228, 1'b1);
    run_scan_phase(32'h0080_0000, 32'd65535, 228, 1'b0);

    // Let everything drain, then watch a while longer for stray points.
    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
